// ===== rtl/dmcsl_pkg.sv =====
package dmcsl_pkg;

	localparam int SPEED_BITS_DEF = 16;
	localparam int DUTY_BITS = 15;
	localparam int STEP_BITS = 15;
	localparam int CODE_BITS = 8;
	localparam logic [STEP_BITS-1:0] RAMP_RESET = 15'd33;

	localparam logic [CODE_BITS-1:0] CODE_MIN = 8'd10;
	localparam logic [CODE_BITS-1:0] CODE_BACK = 8'd100;
	localparam logic [CODE_BITS-1:0] CODE_LIMIT = 8'd40;
	localparam logic [CODE_BITS-1:0] LEFT_BASE = 8'd20;
	localparam logic [CODE_BITS-1:0] RIGHT_BASE = 8'd30;

	localparam int TENTHS_MAX = 9;

	// n tenths of one in a q1.frac word, rounded to nearest, zero past nine tenths
	function automatic longint tenths(input int n, input int frac);
		longint num;
		num = longint'(n) << frac;
		if (n > TENTHS_MAX) begin
			return 0;
		end
		return (num + 5) / 10;
	endfunction

endpackage

// ===== rtl/dual_motor_command_slew_limiter.sv =====
// dual motor command decoder with slew-limited speed ramps
//
// input channel s_axis: one beat is a command byte (tuser = 1, tdata = code)
// or a ramp tick (tuser = 0). an accepted command sets new left/right speed
// targets; a tick moves each current speed at most ramp_step toward its
// target. output channel m_axis: one beat per input beat, in order, carrying
// the forward/reverse duty of both bridges and the command_accepted flag.
// cfg_we/cfg_wdata write ramp_step; the user must do this only while the
// block is idle, as the block itself does not enforce it.
// the result beat is registered: it is presented the cycle after its input
// beat is accepted. one beat per cycle is taken while the receiver does not
// stall: decode, ramp and duty split are one pass of compare/add logic
// between the state registers and the result register.
// if the receiver stalls, the result register holds its beat and s_axis
// tready drops until that beat is taken.
// reset clears all speeds and targets to zero, loads ramp_step with 33 and
// empties the result register.
module dual_motor_command_slew_limiter #(
	parameter int SPEED_BITS = dmcsl_pkg::SPEED_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [14:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // command_code
	input  logic [0:0]  s_axis_tuser,  // cmd
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// left_forward_duty, left_reverse_duty, right_forward_duty,
	// right_reverse_duty, zero pad
	output logic [63:0] m_axis_tdata,
	output logic [0:0]  m_axis_tuser   // command_accepted
);

	localparam int DB = dmcsl_pkg::DUTY_BITS;

	logic signed [SPEED_BITS-1:0] cur_left_q;
	logic signed [SPEED_BITS-1:0] cur_right_q;
	logic signed [SPEED_BITS-1:0] tgt_left_q;
	logic signed [SPEED_BITS-1:0] tgt_right_q;
	logic [dmcsl_pkg::STEP_BITS-1:0] ramp_step_q;

	logic        out_valid_q;
	logic [63:0] out_data_q;
	logic        out_acc_q;

	logic                         in_beat;
	logic                         tick;
	logic                         dec_acc;
	logic signed [SPEED_BITS-1:0] dec_left;
	logic signed [SPEED_BITS-1:0] dec_right;
	logic signed [SPEED_BITS-1:0] nxt_left;
	logic signed [SPEED_BITS-1:0] nxt_right;
	logic [DB-1:0]                lf_duty;
	logic [DB-1:0]                lr_duty;
	logic [DB-1:0]                rf_duty;
	logic [DB-1:0]                rr_duty;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_beat = s_axis_tvalid && s_axis_tready;
	assign tick = !s_axis_tuser[0];

	dmcsl_decode #(.SPEED_BITS(SPEED_BITS)) u_decode (
		.code         (s_axis_tdata),
		.accepted     (dec_acc),
		.target_left  (dec_left),
		.target_right (dec_right)
	);

	dmcsl_ramp #(.SPEED_BITS(SPEED_BITS)) u_ramp_left (
		.tick       (tick),
		.current    (cur_left_q),
		.target     (tgt_left_q),
		.step       (ramp_step_q),
		.next_speed (nxt_left),
		.fwd_duty   (lf_duty),
		.rev_duty   (lr_duty)
	);

	dmcsl_ramp #(.SPEED_BITS(SPEED_BITS)) u_ramp_right (
		.tick       (tick),
		.current    (cur_right_q),
		.target     (tgt_right_q),
		.step       (ramp_step_q),
		.next_speed (nxt_right),
		.fwd_duty   (rf_duty),
		.rev_duty   (rr_duty)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_left_q <= '0;
			cur_right_q <= '0;
			tgt_left_q <= '0;
			tgt_right_q <= '0;
			ramp_step_q <= dmcsl_pkg::RAMP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				ramp_step_q <= cfg_wdata;
			end
			if (in_beat) begin
				cur_left_q <= nxt_left;
				cur_right_q <= nxt_right;
				if (!tick && dec_acc) begin
					tgt_left_q <= dec_left;
					tgt_right_q <= dec_right;
				end
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			out_data_q <= {4'b0000, rr_duty, rf_duty, lr_duty, lf_duty};
			out_acc_q <= !tick && dec_acc;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;
	assign m_axis_tuser = out_acc_q;

endmodule

// ===== rtl/dmcsl_decode.sv =====
module dmcsl_decode #(
	parameter int SPEED_BITS = dmcsl_pkg::SPEED_BITS_DEF
) (
	input  logic [dmcsl_pkg::CODE_BITS-1:0] code,
	output logic                            accepted,
	output logic signed [SPEED_BITS-1:0]    target_left,
	output logic signed [SPEED_BITS-1:0]    target_right
);

	localparam int FRAC_BITS = SPEED_BITS - 1;
	localparam logic signed [SPEED_BITS-1:0] FULL_SCALE =
		{1'b0, {FRAC_BITS{1'b1}}};

	logic [SPEED_BITS-1:0] tenth_tab [16];

	for (genvar i = 0; i < 16; i++) begin : g_tab
		assign tenth_tab[i] = SPEED_BITS'(dmcsl_pkg::tenths(i, FRAC_BITS));
	end

	logic                            back;
	logic [dmcsl_pkg::CODE_BITS-1:0] k;
	logic [dmcsl_pkg::CODE_BITS-1:0] k_off;
	logic                            left_sel;
	logic                            right_sel;
	logic signed [SPEED_BITS-1:0]    mag;
	logic signed [SPEED_BITS-1:0]    val;

	always_comb begin
		back = code >= dmcsl_pkg::CODE_BACK;
		k = back ? code - dmcsl_pkg::CODE_BACK : code;
		accepted = (code >= dmcsl_pkg::CODE_MIN) && (k < dmcsl_pkg::CODE_LIMIT);
		left_sel = (k > dmcsl_pkg::LEFT_BASE) && (k < dmcsl_pkg::RIGHT_BASE);
		right_sel = k > dmcsl_pkg::RIGHT_BASE;
		k_off = left_sel ? k - dmcsl_pkg::LEFT_BASE : k - dmcsl_pkg::RIGHT_BASE;
		mag = (left_sel || right_sel) ? signed'(tenth_tab[k_off[3:0]]) : FULL_SCALE;
		val = back ? -mag : mag;
		target_left = right_sel ? '0 : val;
		target_right = left_sel ? '0 : val;
	end

endmodule

// ===== rtl/dmcsl_ramp.sv =====
module dmcsl_ramp #(
	parameter int SPEED_BITS = dmcsl_pkg::SPEED_BITS_DEF
) (
	input  logic                                 tick,
	input  logic signed [SPEED_BITS-1:0]         current,
	input  logic signed [SPEED_BITS-1:0]         target,
	input  logic [dmcsl_pkg::STEP_BITS-1:0]      step,
	output logic signed [SPEED_BITS-1:0]         next_speed,
	output logic [dmcsl_pkg::DUTY_BITS-1:0]      fwd_duty,
	output logic [dmcsl_pkg::DUTY_BITS-1:0]      rev_duty
);

	localparam int FRAC_BITS = SPEED_BITS - 1;
	localparam int DW = (SPEED_BITS + 1 > dmcsl_pkg::STEP_BITS + 1) ?
		SPEED_BITS + 1 : dmcsl_pkg::STEP_BITS + 1;

	logic signed [DW-1:0]        cur_x;
	logic signed [DW-1:0]        tgt_x;
	logic signed [DW-1:0]        step_x;
	logic signed [DW-1:0]        diff_up;
	logic signed [DW-1:0]        diff_dn;
	logic signed [DW-1:0]        sum_up;
	logic signed [DW-1:0]        sum_dn;
	logic signed [SPEED_BITS-1:0] ramped;
	logic signed [SPEED_BITS-1:0] neg;
	logic [FRAC_BITS-1:0]        mag;
	logic [dmcsl_pkg::DUTY_BITS-1:0] duty;

	always_comb begin
		cur_x = DW'(current);
		tgt_x = DW'(target);
		step_x = signed'({{(DW - dmcsl_pkg::STEP_BITS){1'b0}}, step});
		diff_up = tgt_x - cur_x;
		diff_dn = cur_x - tgt_x;
		sum_up = cur_x + step_x;
		sum_dn = cur_x - step_x;
		if (target > current) begin
			ramped = (diff_up > step_x) ? sum_up[SPEED_BITS-1:0] : target;
		end else if (target < current) begin
			ramped = (diff_dn > step_x) ? sum_dn[SPEED_BITS-1:0] : target;
		end else begin
			ramped = current;
		end
		next_speed = tick ? ramped : current;
		neg = -next_speed;
		mag = next_speed[SPEED_BITS-1] ? neg[FRAC_BITS-1:0] : next_speed[FRAC_BITS-1:0];
	end

	if (FRAC_BITS >= dmcsl_pkg::DUTY_BITS) begin : g_shr
		assign duty = mag[FRAC_BITS-1 -: dmcsl_pkg::DUTY_BITS];
	end else begin : g_shl
		assign duty = {mag, {(dmcsl_pkg::DUTY_BITS - FRAC_BITS){1'b0}}};
	end

	always_comb begin
		if (next_speed > 0) begin
			fwd_duty = duty;
			rev_duty = '0;
		end else begin
			fwd_duty = '0;
			rev_duty = duty;
		end
	end

endmodule

// ===== rtl/dmcsl_checker.sv =====
module dmcsl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata,
	input logic [0:0]  m_axis_tuser
);

	// a stalled result beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
	else $error("stalled result beat changed");

	// input side only waits on a stalled full result register
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
	else $error("input stalled without output backpressure");

	// every input beat gives a result beat next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
	else $error("input beat produced no result beat");

	// a bridge is never driven both ways
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
		(m_axis_tdata[14:0] == 15'd0 || m_axis_tdata[29:15] == 15'd0) &&
		(m_axis_tdata[44:30] == 15'd0 || m_axis_tdata[59:45] == 15'd0))
	else $error("forward and reverse duty both nonzero");

endmodule

bind dual_motor_command_slew_limiter dmcsl_checker u_dmcsl_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
